/* hdl/cop_pkg.sv */
// ----------------------------------------------------------------------------
// cop_pkg
// shared types and constants of the circle octant point generator
// ----------------------------------------------------------------------------
package cop_pkg;

	localparam int unsigned MAX_RADIUS   = 48;
	localparam int unsigned RESULT_LIMIT = 64;

	localparam int unsigned CX_W   = 7;
	localparam int unsigned CY_W   = 6;
	localparam int unsigned RAD_W  = 6;
	localparam int unsigned XO_W   = 9;
	localparam int unsigned YO_W   = 8;
	localparam int unsigned ACC_W  = 14;
	localparam int unsigned CNT_W  = 6;
	localparam int unsigned S_DATA_W = 24;
	localparam int unsigned M_DATA_W = 72;

	// request to the shared square-and-add unit
	typedef struct packed {
		logic [RAD_W-1:0]        op;
		logic                    dbl;
		logic signed [ACC_W-1:0] addend;
	} sq_req_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_INIT = 6'b000010,
		ST_SQA  = 6'b000100,
		ST_SQB  = 6'b001000,
		ST_CHK  = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

endpackage

/* hdl/cop_sqacc.sv */
// ----------------------------------------------------------------------------
// cop_sqacc
// shared square-and-add unit: (dbl ? 2*op*op : op*op) + addend
// ----------------------------------------------------------------------------
module cop_sqacc (
	input  cop_pkg::sq_req_t                    req,
	output logic signed [cop_pkg::ACC_W-1:0]    res
);

	logic [2*cop_pkg::RAD_W-1:0] sq;
	logic [2*cop_pkg::RAD_W:0]   term;

	assign sq   = (2*cop_pkg::RAD_W)'(req.op) * (2*cop_pkg::RAD_W)'(req.op);
	assign term = req.dbl ? {sq, 1'b0} : {1'b0, sq};
	assign res  = $signed(cop_pkg::ACC_W'(term)) + req.addend;

endmodule

/* hdl/circle_octant_point_generator.sv */
// ----------------------------------------------------------------------------
// circle_octant_point_generator
// midpoint circle walk producing the eight symmetric points per step
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one circle: center_x [6:0], center_y [12:7], radius [18:13]
//   m_axis returns one item per step of the walk, eight coordinates packed in
//   tdata, tlast high on the final step of the circle
//   a radius of zero gives no item; a radius above 48 is treated as 48
// timing:
//   the radius is squared first; each step then goes through two squares for
//   the midpoint test, one for the end test, and the emit state that hands
//   the item to the output register; every square uses the single squarer,
//   and the step count is about the radius
//   s_axis_tready is high only while the sequencer is idle
// reset:
//   arst_n clears the sequencer and the output valid; no item is pending
// stalls:
//   the output register holds its item while m_axis_tready is low and the
//   walk waits in the emit state; the last item may still wait while the
//   next circle is already accepted
// ----------------------------------------------------------------------------
module circle_octant_point_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // center_x, center_y, radius, zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // x_center_plus_a, x_center_minus_a,
	                                    // y_center_plus_b, y_center_minus_b,
	                                    // x_center_plus_b, x_center_minus_b,
	                                    // y_center_plus_a, y_center_minus_a,
	                                    // zero pad
	output logic        m_axis_tlast    // last_step
);

	localparam int unsigned RW = cop_pkg::RAD_W;
	localparam int unsigned AW = cop_pkg::ACC_W;
	localparam int unsigned XW = cop_pkg::XO_W;
	localparam int unsigned YW = cop_pkg::YO_W;

	cop_pkg::state_t state_q;

	// held circle and walk offsets
	logic [cop_pkg::CX_W-1:0] cx_q;
	logic [cop_pkg::CY_W-1:0] cy_q;
	logic [RW-1:0]            rad_q;
	logic [RW-1:0]            a_q, b_q;       // offsets of the current step
	logic [RW-1:0]            na_q, nb_q;     // offsets after this step
	logic signed [AW-1:0]     rr_q;           // radius squared
	logic signed [AW-1:0]     acc_q;          // partial midpoint sum
	logic                     last_q;
	logic [cop_pkg::CNT_W-1:0] cnt_q;

	// output register
	logic                     out_valid_q;
	logic                     out_last_q;
	logic [71:0]              out_data_q;

	// input fields
	logic [cop_pkg::CX_W-1:0] in_cx;
	logic [cop_pkg::CY_W-1:0] in_cy;
	logic [RW-1:0]            in_rad;
	logic [RW-1:0]            rad_sat;
	logic                     in_acc;

	// shared unit
	cop_pkg::sq_req_t         req;
	logic signed [AW-1:0]     res;

	logic                     out_free;
	logic signed [XW-1:0]     cx_s, a_x, b_x;
	logic signed [YW-1:0]     cy_s, a_y, b_y;

	assign in_cx   = s_axis_tdata[6:0];
	assign in_cy   = s_axis_tdata[12:7];
	assign in_rad  = s_axis_tdata[18:13];
	assign rad_sat = (in_rad > RW'(cop_pkg::MAX_RADIUS)) ? RW'(cop_pkg::MAX_RADIUS) : in_rad;

	assign s_axis_tready = (state_q == cop_pkg::ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// operand selection for the squarer
	always_comb begin
		req.op     = '0;
		req.dbl    = 1'b0;
		req.addend = '0;
		unique case (state_q)
			cop_pkg::ST_INIT: begin
				req.op = rad_q;
			end
			cop_pkg::ST_SQA: begin
				// (a+1)^2 - r^2
				req.op     = a_q + RW'(1);
				req.addend = -rr_q;
			end
			cop_pkg::ST_SQB: begin
				// ... + b^2
				req.op     = b_q;
				req.addend = acc_q;
			end
			cop_pkg::ST_CHK: begin
				// 2*b'^2 - r^2, negative ends the walk
				req.op     = nb_q;
				req.dbl    = 1'b1;
				req.addend = -rr_q;
			end
			default: begin
				req.op     = '0;
				req.dbl    = 1'b0;
				req.addend = '0;
			end
		endcase
	end

	cop_sqacc u_sqacc (
		.req (req),
		.res (res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cop_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				cop_pkg::ST_IDLE: begin
					if (in_acc && rad_sat != '0) begin
						state_q <= cop_pkg::ST_INIT;
					end
					cnt_q <= '0;
				end
				cop_pkg::ST_INIT: state_q <= cop_pkg::ST_SQA;
				cop_pkg::ST_SQA:  state_q <= cop_pkg::ST_SQB;
				cop_pkg::ST_SQB:  state_q <= cop_pkg::ST_CHK;
				cop_pkg::ST_CHK:  state_q <= cop_pkg::ST_EMIT;
				cop_pkg::ST_EMIT: begin
					if (out_free) begin
						cnt_q   <= cnt_q + cop_pkg::CNT_W'(1);
						state_q <= last_q ? cop_pkg::ST_IDLE : cop_pkg::ST_SQA;
					end
				end
				default: state_q <= cop_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			cop_pkg::ST_IDLE: begin
				if (in_acc) begin
					cx_q  <= in_cx;
					cy_q  <= in_cy;
					rad_q <= rad_sat;
					a_q   <= '0;
					b_q   <= rad_sat;
				end
			end
			cop_pkg::ST_INIT: rr_q  <= res;
			cop_pkg::ST_SQA:  acc_q <= res;
			cop_pkg::ST_SQB: begin
				// midpoint outside the circle: step b inward, keep a
				if (res > 0) begin
					na_q <= a_q;
					nb_q <= b_q - RW'(1);
				end else begin
					na_q <= a_q + RW'(1);
					nb_q <= b_q;
				end
			end
			cop_pkg::ST_CHK: begin
				last_q <= res[AW-1] ||
				          (cnt_q == cop_pkg::CNT_W'(cop_pkg::RESULT_LIMIT - 1));
			end
			cop_pkg::ST_EMIT: begin
				if (out_free) begin
					a_q <= na_q;
					b_q <= nb_q;
				end
			end
			default: begin
			end
		endcase
	end

	// coordinates of the current step
	assign cx_s = $signed(XW'(cx_q));
	assign a_x  = $signed(XW'(a_q));
	assign b_x  = $signed(XW'(b_q));
	assign cy_s = $signed(YW'(cy_q));
	assign a_y  = $signed(YW'(a_q));
	assign b_y  = $signed(YW'(b_q));

	// output register, loads when the emit state finds it free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == cop_pkg::ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cop_pkg::ST_EMIT && out_free) begin
			out_last_q <= last_q;
			out_data_q <= {4'b0000,
			               cy_s - a_y, cy_s + a_y,
			               cx_s - b_x, cx_s + b_x,
			               cy_s - b_y, cy_s + b_y,
			               cx_s - a_x, cx_s + a_x};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule
